>>> src/lzd_pkg.sv
package lzd_pkg;

   // History window and size counter widths
   localparam int HIST_DEPTH = 4096;
   localparam int HIST_AW    = $clog2(HIST_DEPTH);
   localparam int SIZE_BITS  = 24;
   localparam int LEN_BITS   = 5;
   localparam int DIST_BITS  = HIST_AW + 1;

   // Header and flag group constants
   localparam logic [2:0]          HDR_BYTES  = 3'd4;
   localparam logic [3:0]          FLAG_COUNT = 4'd8;
   localparam logic [LEN_BITS-1:0] LEN_BASE   = LEN_BITS'(3);
   localparam logic [LEN_BITS-1:0] LIT_LEN    = LEN_BITS'(1);

   // Parser phase
   typedef enum logic [1:0] {
      PH_HEADER,
      PH_DATA,
      PH_REF,
      PH_DONE
   } phase_type;

   // Copy sequencer state
   typedef enum logic [1:0] {
      CP_IDLE,
      CP_READ,
      CP_EMIT
   } copy_state_type;

   // Command from the parser to the copy unit
   typedef struct packed {
      logic                 go;
      logic                 restart;
      logic                 is_ref;
      logic [7:0]           lit;
      logic [LEN_BITS-1:0]  length;
      logic [DIST_BITS-1:0] offset;
      logic [SIZE_BITS-1:0] target;
   } cmd_type;

   // Status from the copy unit to the parser
   typedef struct packed {
      logic busy;
      logic done;
   } sts_type;

endpackage

>>> src/lzd_ram.sv
module lzd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/lzd_copy.sv
module lzd_copy (
   input  logic             clock,
   input  logic             reset,
   input  lzd_pkg::cmd_type cmd,
   output lzd_pkg::sts_type sts,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [7:0]       rsp_tdata,  // out_byte
   output logic             rsp_tlast,  // run_last
   output logic [1:0]       rsp_tuser   // [0] stream_done, [1] bad_reference
);
   import lzd_pkg::*;

   copy_state_type       state_ff, state_in;
   logic [LEN_BITS-1:0]  remain_ff, remain_in;
   logic [DIST_BITS-1:0] dist_ff, dist_in;
   logic [7:0]           lit_ff, lit_in;
   logic                 is_ref_ff, is_ref_in;
   logic                 bad_ff, bad_in;
   logic [HIST_AW-1:0]   widx_ff, widx_in;
   logic [SIZE_BITS-1:0] prod_ff, prod_in;
   logic                 out_vld_ff, out_vld_in;
   logic [7:0]           out_byte_ff, out_byte_in;
   logic                 out_last_ff, out_last_in;
   logic                 out_done_ff, out_done_in;
   logic                 out_bad_ff, out_bad_in;

   logic                 free;
   logic                 fire;
   logic                 hit;
   logic                 rd_en;
   logic [HIST_AW-1:0]   rd_addr;
   logic [7:0]           rd_data;
   logic [SIZE_BITS-1:0] prod_next;
   logic [7:0]           emit_byte;

   // History window
   lzd_ram #(
      .WIDTH(8),
      .DEPTH(HIST_DEPTH)
   ) u_hist (
      .clock   (clock),
      .wr_en   (fire),
      .wr_addr (widx_ff),
      .wr_data (emit_byte),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Shared address and count arithmetic
   assign free      = !out_vld_ff || rsp_tready;
   assign rd_addr   = widx_ff - dist_ff[HIST_AW-1:0];
   assign prod_next = prod_ff + 1'b1;
   assign hit       = (prod_next == cmd.target);
   assign emit_byte = !is_ref_ff ? lit_ff : (bad_ff ? 8'h00 : rd_data);

   // Sequencer: for a reference, read one history byte, then emit it; a literal is emitted directly
   always_comb begin
      state_in    = state_ff;
      remain_in   = remain_ff;
      dist_in     = dist_ff;
      lit_in      = lit_ff;
      is_ref_in   = is_ref_ff;
      bad_in      = bad_ff;
      widx_in     = widx_ff;
      prod_in     = prod_ff;
      out_vld_in  = out_vld_ff;
      out_byte_in = out_byte_ff;
      out_last_in = out_last_ff;
      out_done_in = out_done_ff;
      out_bad_in  = out_bad_ff;
      fire        = 1'b0;
      rd_en       = 1'b0;

      // drop the word once taken
      if (out_vld_ff && rsp_tready) begin
         out_vld_in = 1'b0;
      end

      case (state_ff)
         CP_IDLE: begin
            if (cmd.go) begin
               remain_in = cmd.length;
               dist_in   = cmd.offset;
               lit_in    = cmd.lit;
               is_ref_in = cmd.is_ref;
               bad_in    = 1'b0;
               state_in  = cmd.is_ref ? CP_READ : CP_EMIT;
            end
         end
         CP_READ: begin
            rd_en    = 1'b1;
            bad_in   = ({{(SIZE_BITS-DIST_BITS){1'b0}}, dist_ff} > prod_ff);
            state_in = CP_EMIT;
         end
         CP_EMIT: begin
            if (free) begin
               fire        = 1'b1;
               widx_in     = widx_ff + 1'b1;
               prod_in     = prod_next;
               remain_in   = remain_ff - 1'b1;
               out_vld_in  = 1'b1;
               out_byte_in = emit_byte;
               out_last_in = hit || (remain_ff == LIT_LEN);
               out_done_in = hit;
               out_bad_in  = is_ref_ff && bad_ff;
               state_in    = (hit || remain_ff == LIT_LEN) ? CP_IDLE : CP_READ;
            end
         end
         default: begin
            state_in = CP_IDLE;
         end
      endcase

      // restart the window pointer and count for a new stream
      if (cmd.restart) begin
         widx_in = '0;
         prod_in = '0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= CP_IDLE;
         widx_ff    <= '0;
         prod_ff    <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         widx_ff    <= widx_in;
         prod_ff    <= prod_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      remain_ff   <= remain_in;
      dist_ff     <= dist_in;
      lit_ff      <= lit_in;
      is_ref_ff   <= is_ref_in;
      bad_ff      <= bad_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
      out_done_ff <= out_done_in;
      out_bad_ff  <= out_bad_in;
   end

   assign sts.busy   = (state_ff != CP_IDLE);
   assign sts.done   = fire && hit;
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = {out_bad_ff, out_done_ff};

   // Checks
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tlast)
      else $error("stream_done word without run_last");

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tdata == 8'h00)
      else $error("bad reference word carries nonzero data");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      sts.done |=> state_ff == CP_IDLE)
      else $error("copy continued past declared size");

endmodule

>>> src/lz77_stream_decompressor.sv
// Channel | Dir | Handshake             | Payload
// req     | in  | req_tvalid/req_tready | tdata[7:0] in_byte, tuser start_req
// rsp     | out | rsp_tvalid/rsp_tready | tdata[7:0] out_byte, tlast run_last,
//         |     |                       | tuser[0] stream_done, tuser[1] bad_reference
//
// Header, flag and first reference bytes are absorbed by the parser without a copy.
// A literal is accepted, then emitted from the emit state.
// A reference's second byte starts a copy of N bytes: each byte is one history read
// on the single RAM read port and then one emit/write.
// Reset is synchronous; history contents are not cleared.
// A stalled rsp side holds the emit state; req_tready stays low until the copy ends.
module lz77_stream_decompressor (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,  // in_byte
   input  logic       req_tuser,  // start_req
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,  // out_byte
   output logic       rsp_tlast,  // run_last
   output logic [1:0] rsp_tuser   // [0] stream_done, [1] bad_reference
);
   import lzd_pkg::*;

   phase_type            phase_ff, phase_in;
   logic [2:0]           hc_ff, hc_in;
   logic [SIZE_BITS-1:0] target_ff, target_in;
   logic [7:0]           flag_ff, flag_in;
   logic [3:0]           pos_ff, pos_in;
   logic [7:0]           pend_ff, pend_in;

   cmd_type cmd;
   sts_type sts;
   logic    accept;

   assign req_tready = !sts.busy;
   assign accept     = req_tvalid && req_tready;

   // Copy and emit unit
   lzd_copy u_copy (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // Parse header, flag and reference bytes
   always_comb begin
      logic [3:0] pos_m1;
      phase_in  = phase_ff;
      hc_in     = hc_ff;
      target_in = target_ff;
      flag_in   = flag_ff;
      pos_in    = pos_ff;
      pend_in   = pend_ff;
      pos_m1    = pos_ff - 4'd1;

      cmd         = '0;
      cmd.target  = target_ff;
      cmd.lit     = req_tdata;
      cmd.length  = LIT_LEN;

      if (accept) begin
         // start a new stream
         if (req_tuser) begin
            phase_in    = PH_HEADER;
            hc_in       = '0;
            target_in   = '0;
            flag_in     = '0;
            pos_in      = '0;
            pend_in     = '0;
            cmd.restart = 1'b1;
         end
         pos_m1 = pos_in - 4'd1;

         case (phase_in)
            PH_HEADER: begin
               if (hc_in != 3'd0 && hc_in < HDR_BYTES) begin
                  target_in = target_in |
                              (SIZE_BITS'(req_tdata) << {hc_in - 3'd1, 3'b000});
               end
               hc_in = hc_in + 3'd1;
               if (hc_in == HDR_BYTES) begin
                  pos_in   = '0;
                  phase_in = (target_in == '0) ? PH_DONE : PH_DATA;
               end
            end
            PH_DATA: begin
               if (pos_in == 4'd0) begin
                  flag_in = req_tdata;
                  pos_in  = FLAG_COUNT;
               end else if (flag_in[pos_m1[2:0]]) begin
                  pend_in  = req_tdata;
                  phase_in = PH_REF;
               end else begin
                  pos_in = pos_m1;
                  cmd.go = 1'b1;
               end
            end
            PH_REF: begin
               cmd.go     = 1'b1;
               cmd.is_ref = 1'b1;
               cmd.length = LEN_BITS'(pend_in[7:4]) + LEN_BASE;
               cmd.offset = {1'b0, pend_in[3:0], req_tdata} + DIST_BITS'(1);
               pos_in     = pos_m1;
               phase_in   = PH_DATA;
            end
            default: begin
               // done: ignore input until a new stream starts
            end
         endcase
      end

      // hold the done phase once the declared size is reached
      if (sts.done) begin
         phase_in = PH_DONE;
      end
   end

   // Parser registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HEADER;
         hc_ff     <= '0;
         target_ff <= '0;
         flag_ff   <= '0;
         pos_ff    <= '0;
         pend_ff   <= '0;
      end else begin
         phase_ff  <= phase_in;
         hc_ff     <= hc_in;
         target_ff <= target_in;
         flag_ff   <= flag_in;
         pos_ff    <= pos_in;
         pend_ff   <= pend_in;
      end
   end

   // Checks
   a_done_quiet: assert property (@(posedge clock) disable iff (reset)
      accept && phase_ff == PH_DONE && !req_tuser |-> !cmd.go)
      else $error("byte emitted after stream completion");

   a_go_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.go |=> sts.busy)
      else $error("copy unit did not take command");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("stalled output word changed");

endmodule

>>> test/lz77_stream_decompressor_tb.sv
`timescale 1ns / 1ps

module lz77_stream_decompressor_tb;
   import lzd_pkg::*;

   // One decompressed byte as it should leave the block
   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       done;
      logic       bad;
   } out_word_type;

   // Decoder mirror: tracks header, flag groups and the history window
   class decomp_scoreboard;
      bit [7:0]           window [HIST_DEPTH];
      bit [HIST_AW-1:0]   wr_ptr;
      bit [SIZE_BITS-1:0] produced;
      bit [SIZE_BITS-1:0] target;
      bit [2:0]           hdr_count;
      bit [7:0]           flag_byte;
      bit [3:0]           flag_pos;
      bit [7:0]           ref_head;
      phase_type          phase;
      out_word_type       expected_bytes [$];
      int                 errors;

      function new();
         restart();
         errors = 0;
      endfunction

      function void restart();
         wr_ptr    = '0;
         produced  = '0;
         target    = '0;
         hdr_count = '0;
         flag_byte = '0;
         flag_pos  = '0;
         ref_head  = '0;
         phase     = PH_HEADER;
      endfunction

      // Write one byte to the window and queue it as an expected output
      function void append(bit [7:0] value, bit bad);
         out_word_type w;
         window[wr_ptr] = value;
         wr_ptr++;
         produced++;
         w.data = value;
         w.last = 1'b0;
         w.done = (produced == target);
         w.bad  = bad;
         if (w.done) begin
            phase = PH_DONE;
         end
         expected_bytes.push_back(w);
      endfunction

      // Advance the decoder by one accepted compressed byte
      function void note_input_byte(bit [7:0] b, bit start);
         int unsigned      count;
         int unsigned      span;
         bit [12:0]        offset;
         bit [HIST_AW-1:0] src;
         out_word_type     w;
         count = 0;
         if (start) begin
            restart();
         end
         case (phase)
            PH_HEADER: begin
               // type byte is skipped, the next three carry the size
               if (hdr_count >= 1 && hdr_count <= 3) begin
                  target |= SIZE_BITS'(b) << (8 * (hdr_count - 1));
               end
               hdr_count++;
               if (hdr_count == HDR_BYTES) begin
                  flag_pos = '0;
                  phase    = (target == 0) ? PH_DONE : PH_DATA;
               end
            end
            PH_DATA: begin
               if (flag_pos == 0) begin
                  flag_byte = b;
                  flag_pos  = FLAG_COUNT;
               end else if (flag_byte[flag_pos - 1]) begin
                  ref_head = b;
                  phase    = PH_REF;
               end else begin
                  flag_pos--;
                  append(b, 1'b0);
                  count = 1;
               end
            end
            PH_REF: begin
               span   = ref_head[7:4] + 3;
               offset = {1'b0, ref_head[3:0], b} + 13'd1;
               flag_pos--;
               phase = PH_DATA;
               // copy may overlap itself and stops at the declared size
               while (count < span && phase != PH_DONE) begin
                  if (offset > produced) begin
                     append(8'h00, 1'b1);
                  end else begin
                     src = wr_ptr - offset[HIST_AW-1:0];
                     append(window[src], 1'b0);
                  end
                  count++;
               end
            end
            default: ;
         endcase
         // flag the last byte caused by this input
         if (count > 0) begin
            w = expected_bytes.pop_back();
            w.last = 1'b1;
            expected_bytes.push_back(w);
         end
      endfunction

      // Compare one accepted output word against the oldest expectation
      function void check_output_byte(logic [7:0] data, logic last, logic [1:0] flags);
         out_word_type w;
         if (expected_bytes.size() == 0) begin
            $display("%0t: unexpected output word, actual data %h", $time, data);
            errors++;
            return;
         end
         w = expected_bytes.pop_front();
         if (data !== w.data) begin
            $display("%0t: out_byte expected %h actual %h", $time, w.data, data);
            errors++;
         end
         if (last !== w.last) begin
            $display("%0t: run_last expected %b actual %b", $time, w.last, last);
            errors++;
         end
         if (flags[0] !== w.done) begin
            $display("%0t: stream_done expected %b actual %b", $time, w.done, flags[0]);
            errors++;
         end
         if (flags[1] !== w.bad) begin
            $display("%0t: bad_reference expected %b actual %b", $time, w.bad, flags[1]);
            errors++;
         end
      endfunction

      function int pending();
         return expected_bytes.size();
      endfunction
   endclass

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;  // in_byte
   logic       req_tuser  = 1'b0;   // start_req
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // out_byte
   logic       rsp_tlast;           // run_last
   logic [1:0] rsp_tuser;           // [0] stream_done, [1] bad_reference

   decomp_scoreboard sb;
   int unsigned      items_sent  = 0;
   bit               req_idle_on = 1'b1;
   bit               rsp_stall_on = 1'b1;
   bit               hold_req    = 1'b0;

   lz77_stream_decompressor u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always #1 clock = ~clock;

   // Offer one compressed word and hold it until accepted
   task automatic send_byte(input bit [7:0] value, input bit start);
      if (req_idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tuser  <= start;
      do @(posedge clock); while (!req_tready);
      sb.note_input_byte(value, start);
      items_sent++;
   endtask

   // Drop valid and wait until every expected word has come out
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // Header plus flag groups of literals and references; a body that is not
   // well formed is replaced by random words
   task automatic send_stream(input int unsigned size, input int unsigned ref_pct,
                              input int unsigned wild_pct, input int unsigned min_len,
                              input int unsigned max_len, input int unsigned tail,
                              input bit well_formed);
      bit [7:0]    group_bytes [$];
      bit [7:0]    flag;
      bit [11:0]   dcode;
      bit [3:0]    lcode;
      int unsigned made;
      int unsigned len;
      int unsigned offset;
      int          i;
      send_byte(8'($urandom_range(0, 255)), 1'b1);
      send_byte(size[7:0], 1'b0);
      send_byte(size[15:8], 1'b0);
      send_byte(size[23:16], 1'b0);
      made = 0;
      while (well_formed && made < size) begin
         group_bytes.delete();
         flag = 8'h00;
         for (i = 7; i >= 0 && made < size; i--) begin
            if ($urandom_range(0, 99) < ref_pct) begin
               flag[i] = 1'b1;
               len = $urandom_range(min_len, max_len);
               if (made == 0 || $urandom_range(0, 99) < wild_pct) begin
                  offset = $urandom_range(1, HIST_DEPTH);
               end else begin
                  offset = $urandom_range(1, (made < HIST_DEPTH) ? made : HIST_DEPTH);
               end
               lcode = 4'(len - 3);
               dcode = 12'(offset - 1);
               group_bytes.push_back({lcode, dcode[11:8]});
               group_bytes.push_back(dcode[7:0]);
               made += len;
            end else begin
               group_bytes.push_back(8'($urandom_range(0, 255)));
               made++;
            end
         end
         send_byte(flag, 1'b0);
         foreach (group_bytes[k]) begin
            send_byte(group_bytes[k], 1'b0);
         end
      end
      repeat (tail) send_byte(8'($urandom_range(0, 255)), 1'b0);
   endtask

   // Mostly well-formed streams, some noise and some cut-off headers
   task automatic random_stream();
      int unsigned kind;
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
         send_stream($urandom_range(1, 30), 0, 0, 3, 18, $urandom_range(1, 24), 1'b0);
      end else if (kind == 1) begin
         send_byte(8'($urandom_range(0, 255)), 1'b1);
         repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(0, 255)), 1'b0);
      end else begin
         send_stream($urandom_range(1, 48), $urandom_range(0, 80), 10, 3, 18,
                     $urandom_range(0, 2), 1'b1);
      end
   endtask

   // Check every word the block hands over
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_output_byte(rsp_tdata, rsp_tlast, rsp_tuser);
      end
   end

   // Receiver: random stalls, or one long hold on request
   initial begin
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_req) begin
            rsp_tready <= 1'b0;
            repeat (300) @(posedge clock);
            hold_req = 1'b0;
         end else if (rsp_stall_on && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   initial begin
      #2000000;
      $display("FAILURE");
      $finish;
   end

   initial begin
      int unsigned goal;
      sb = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // first stream without start: literal 0xFF, overlapping copy at distance 1,
      // literal 0x00, then one ignored word after completion
      send_byte(8'h10, 1'b0);
      send_byte(8'h05, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h40, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hAB, 1'b0);
      // zero declared size: nothing comes out
      send_byte(8'h10, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      // longest copy at the farthest distance before any output, cut at size 4
      send_byte(8'h10, 1'b1);
      send_byte(8'h04, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      // largest size, abandoned by the restart of the next stream
      send_byte(8'h11, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h7E, 1'b0);
      wait_drained();

      // random streams with mixed idling
      goal = items_sent + 85;
      while (items_sent < goal) begin
         req_idle_on  = ($urandom_range(0, 3) != 0);
         rsp_stall_on = ($urandom_range(0, 3) != 0);
         random_stream();
      end

      // long receiver hold while the sender keeps offering, then a full drain
      req_idle_on  = 1'b0;
      rsp_stall_on = 1'b1;
      hold_req     = 1'b1;
      send_stream(60, 60, 5, 3, 18, 0, 1'b1);
      req_tvalid <= 1'b0;
      while (hold_req) @(posedge clock);
      wait_drained();

      // closing part at full rate on both sides
      req_idle_on  = 1'b0;
      rsp_stall_on = 1'b0;
      goal = items_sent + 75;
      while (items_sent < goal) begin
         random_stream();
      end
      wait_drained();
      repeat (64) @(posedge clock);

      if (sb.pending() != 0) begin
         $display("%0t: %0d expected words never arrived", $time, sb.pending());
         sb.errors++;
      end
      if (sb.errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
